// ----- src/fca_pkg.sv -----
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, sizes and register indexes of the falling-cell stepper.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int NUM_TYPES = 8;
  localparam int MAX_ROW   = 1024;
  localparam int PAD       = 2;
  localparam int MAX_H     = 4096;

  localparam int CELL_W = 8;
  localparam int COL_W  = $clog2(MAX_ROW);
  localparam int ROW_W  = 13;
  localparam int CFG_W  = 64;

  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_DOWN        = 3'd2,
    REG_DIAG        = 3'd3,
    REG_SIDE        = 3'd4,
    REG_SIDE_DIR    = 3'd5,
    REG_TURNED      = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2,
    DIR_UNUSED = 2'd3
  } side_dir_t;

  function automatic logic [2:0] cell_type(input cell_t c);
    logic [2:0] t;
    t = 3'd0;
    for (int i = 1; i < CELL_W; i++) begin
      if (c[i]) t = 3'(i);
    end
    return t;
  endfunction

  function automatic cell_t type_byte(input logic [63:0] r, input logic [2:0] t);
    cell_t b;
    b = '0;
    if (int'(t) < NUM_TYPES) b = r[8*t +: 8];
    return b;
  endfunction

  function automatic logic dir_match(input logic [15:0] r, input logic [2:0] t,
                                     input logic pl);
    logic [1:0] code;
    code = r[2*t +: 2];
    return (int'(t) < NUM_TYPES) &&
           (code == (pl ? 2'(DIR_PLUS) : 2'(DIR_MINUS)));
  endfunction

endpackage

// ----- src/fca_cell_if.sv -----
// ----------------------------------------------------------------------------
// fca_cell_if
// Input channel: one padded-grid cell per beat.
// ----------------------------------------------------------------------------
interface fca_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_in;
  modport source (output valid, output cell_in, input ready);
  modport sink   (input valid, input cell_in, output ready);
endinterface

// ----- src/fca_result_if.sv -----
// ----------------------------------------------------------------------------
// fca_result_if
// Output channel: one next-generation interior cell per beat.
// ----------------------------------------------------------------------------
interface fca_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_out;
  logic       frame_last;
  modport source (output valid, output cell_out, output frame_last, input ready);
  modport sink   (input valid, input cell_out, input frame_last, output ready);
endinterface

// ----- src/falling_cell_automaton_step.sv -----
// ----------------------------------------------------------------------------
// falling_cell_automaton_step
// Streams a padded grid and emits the next generation of its interior cells.
// ----------------------------------------------------------------------------
// One cell beat is taken every cycle unless a result is held at a stalled output.
// Four line buffers live in a single 1024 x 32 synchronous memory read one
// column ahead and written back shifted in the same cycle; a 5x5 register
// window feeds a registered rule stage; a result follows the padded cell two
// rows down and two columns on. Padding positions give no result beat.
module falling_cell_automaton_step import fca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fca_cell_if.sink           cells_in,
  fca_result_if.source       cells_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic [9:0]  grid_width;
  logic [12:0] grid_height;
  logic [63:0] down_masks, diagonal_masks, side_masks, turned_cells;
  logic [15:0] side_directions;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= 10'd64;
      grid_height     <= 13'd64;
      down_masks      <= '0;
      diagonal_masks  <= '0;
      side_masks      <= '0;
      side_directions <= '0;
      turned_cells    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width      <= cfg_data[9:0];
        REG_GRID_HEIGHT: grid_height     <= cfg_data[12:0];
        REG_DOWN:        down_masks      <= cfg_data;
        REG_DIAG:        diagonal_masks  <= cfg_data;
        REG_SIDE:        side_masks      <= cfg_data;
        REG_SIDE_DIR:    side_directions <= cfg_data[15:0];
        REG_TURNED:      turned_cells    <= cfg_data;
        default: ;
      endcase
    end
  end

  // geometry
  logic [10:0] w_eff, pw;
  logic [13:0] h_eff, ph;
  always_comb begin
    w_eff = {1'b0, grid_width};
    if (w_eff < 11'd1) w_eff = 11'd1;
    if (w_eff > 11'(MAX_ROW - 2*PAD)) w_eff = 11'(MAX_ROW - 2*PAD);
    h_eff = {1'b0, grid_height};
    if (h_eff < 14'd1) h_eff = 14'd1;
    if (h_eff > 14'(MAX_H)) h_eff = 14'(MAX_H);
    pw = w_eff + 11'(2*PAD);
    ph = h_eff + 14'(2*PAD);
  end

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             priority_left, priority_left_next;
  logic             in_acc, row_end, frame_end, emit, last;

  logic             s1_valid, s1_emit, s1_last, s1_pl, s1_adv;
  logic             out_valid;

  assign s1_adv         = s1_valid && (!s1_emit || !out_valid || cells_out.ready);
  assign cells_in.ready = !rst && (!s1_valid || s1_adv);
  assign in_acc         = cells_in.valid && cells_in.ready;

  always_comb begin
    row_end   = {1'b0, column_count} >= pw - 11'd1;
    frame_end = {1'b0, row_count} >= ph - 14'd1;
    emit = {1'b0, row_count} >= 14'(PAD + 2) && {1'b0, row_count} < 14'(PAD + 2) + h_eff &&
           {1'b0, column_count} >= 11'(PAD + 2) &&
           {1'b0, column_count} < 11'(PAD + 2) + w_eff;
    last = {1'b0, row_count} == 14'(PAD + 1) + h_eff &&
           {1'b0, column_count} == 11'(PAD + 1) + w_eff;
    column_count_next  = column_count + 1'b1;
    row_count_next     = row_count;
    priority_left_next = priority_left;
    if (row_end) begin
      column_count_next = '0;
      if (frame_end) begin
        row_count_next     = '0;
        priority_left_next = !priority_left;
      end else begin
        row_count_next = row_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      priority_left <= 1'b1;
    end else if (in_acc) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      priority_left <= priority_left_next;
    end
  end

  // line buffers: lane k holds row k+1 above the current one
  logic [4*CELL_W-1:0] row_store [MAX_ROW];
  logic [4*CELL_W-1:0] rd_data;
  logic [COL_W-1:0]    rd_addr;

  assign rd_addr = in_acc ? column_count_next : column_count;

  always_ff @(posedge clk) begin
    rd_data <= row_store[rd_addr];
    if (in_acc) row_store[column_count] <= {rd_data[3*CELL_W-1:0], cells_in.cell_in};
  end

  // window[k][j]: k row age, j column age
  cell_t window [5][5];
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 5; k++) begin
        for (int j = 4; j > 0; j--) window[k][j] <= window[k][j-1];
      end
      window[0][0] <= cells_in.cell_in;
      for (int k = 1; k < 5; k++) window[k][0] <= rd_data[CELL_W*(k-1) +: CELL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit <= emit;
      s1_last <= last;
      s1_pl   <= priority_left;
    end
  end

  // rule evaluation
  cell_t next_value;
  always_comb begin
    logic [2:0] pc, mc, p2, m2;
    cell_t self, up1, up2, dn1, up1_p, c0_p, up2_p, up2_2p, dn1_m, dn2_m, c0_m;
    cell_t c0_2p, dn1_p, up1_2p, up1_m, dn1_m2;
    logic  done, turn;
    cell_t turned;
    pc = s1_pl ? 3'd1 : 3'd3;
    mc = s1_pl ? 3'd3 : 3'd1;
    p2 = s1_pl ? 3'd0 : 3'd4;
    m2 = s1_pl ? 3'd4 : 3'd0;
    self   = window[2][2];
    up1    = window[3][2];
    up2    = window[4][2];
    dn1    = window[1][2];
    up1_p  = window[3][pc];
    c0_p   = window[2][pc];
    up2_p  = window[4][pc];
    up2_2p = window[4][p2];
    dn1_m  = window[1][mc];
    dn2_m  = window[0][mc];
    c0_m   = window[2][mc];
    c0_2p  = window[2][p2];
    dn1_p  = window[1][pc];
    up1_2p = window[3][p2];
    up1_m  = window[3][mc];
    dn1_m2 = window[1][m2];
    done   = 1'b0;
    turn   = 1'b0;
    turned = '0;
    next_value = self;
    if (|(up1 & type_byte(down_masks, cell_type(self))) &&
        !(|(up2 & type_byte(down_masks, cell_type(up1))))) begin
      next_value = up1; done = 1'b1;
    end else if (|(self & type_byte(down_masks, cell_type(dn1)))) begin
      next_value = dn1; done = 1'b1;
    end else if (|(up1_p & type_byte(diagonal_masks, cell_type(self))) &&
                 !(|(up1_p & type_byte(down_masks, cell_type(c0_p)))) &&
                 !(|(up2_p & type_byte(down_masks, cell_type(up1_p)))) &&
                 !(|(up2_2p & type_byte(diagonal_masks, cell_type(up1_p))))) begin
      next_value = up1_p; done = 1'b1;
    end else if (|(self & type_byte(diagonal_masks, cell_type(dn1_m))) &&
                 !(|(dn1_m & type_byte(down_masks, cell_type(dn2_m)))) &&
                 !(|(c0_m & type_byte(down_masks, cell_type(dn1_m))))) begin
      next_value = dn1_m; done = 1'b1;
    end
    if (!done && dir_match(side_directions, cell_type(self), s1_pl)) begin
      if (|(c0_p & type_byte(side_masks, cell_type(self))) &&
          !(|(c0_2p & type_byte(side_masks, cell_type(c0_p)))) &&
          !(|(up1_p & type_byte(down_masks, cell_type(c0_p)))) &&
          !(|(c0_p & type_byte(down_masks, cell_type(dn1_p)))) &&
          !(|(up1_2p & type_byte(diagonal_masks, cell_type(c0_p)))) &&
          !(|(c0_p & type_byte(diagonal_masks, cell_type(dn1))))) begin
        next_value = c0_p; done = 1'b1;
      end else begin
        turn   = 1'b1;
        turned = type_byte(turned_cells, cell_type(self));
      end
    end
    if (!done && dir_match(side_directions, cell_type(c0_m), s1_pl) &&
        |(self & type_byte(side_masks, cell_type(c0_m))) &&
        !(|(up1_m & type_byte(down_masks, cell_type(c0_m)))) &&
        !(|(c0_m & type_byte(down_masks, cell_type(dn1_m)))) &&
        !(|(up1 & type_byte(diagonal_masks, cell_type(c0_m)))) &&
        !(|(c0_m & type_byte(diagonal_masks, cell_type(dn1_m2))))) begin
      next_value = c0_m; done = 1'b1;
    end
    if (!done && turn) next_value = turned;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (cells_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      cells_out.cell_out   <= next_value;
      cells_out.frame_last <= s1_last;
    end
  end

  assign cells_out.valid = out_valid;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit && out_valid && !cells_out.ready) |-> !cells_in.ready)
    else $error("input taken while rule stage is stalled");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && row_end) |=> column_count == '0)
    else $error("column count did not wrap at row end");

  a_frame_flip: assert property (@(posedge clk) disable iff (rst)
    (in_acc && row_end && frame_end) |=> priority_left != $past(priority_left))
    else $error("priority direction did not flip at frame end");

  a_last_is_emit: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last) |-> emit)
    else $error("frame end flagged on a padding cell");

endmodule
